// File: rtl/core/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared widths, types and structs of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned NumFrames = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned PageW     = 16;
  localparam int unsigned RankW     = 4;
  localparam int unsigned OldRankW  = RankW + 1;
  localparam int unsigned CntW      = 32;
  localparam int unsigned CfgW      = 5;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [PageW-1:0]    page_t;
  typedef logic [RankW-1:0]    rank_t;
  typedef logic [OldRankW-1:0] old_rank_t;

  localparam rank_t     RankMax   = {RankW{1'b1}};
  // old rank assumed for a frame that was empty before the fill
  localparam old_rank_t EmptyRank = {1'b1, {RankW{1'b0}}};

  // frame update issued once per reference
  typedef struct packed {
    logic      en;
    idx_t      slot;
    old_rank_t old_rank;
    logic      write_page;
    logic      set_valid;
    page_t     page;
  } upd_t;

  // accumulated outcome of one pass over the frames
  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    rank_t hit_rank;
    logic  empty;
    idx_t  empty_idx;
    idx_t  vic_idx;
    rank_t vic_rank;
    page_t vic_page;
  } scan_t;

endpackage

// File: rtl/core/lrupr_store.sv
// ----------------------------------------------------------------------------
// lrupr_store
// Frame store: page numbers, valid marks and recency ranks, with the
// recency update and the clear after the last reference.
// ----------------------------------------------------------------------------
module lrupr_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrupr_pkg::idx_t      rd_idx_i,
  output logic                 rd_valid_o,
  output lrupr_pkg::rank_t     rd_rank_o,
  output lrupr_pkg::page_t     rd_page_o,
  input  lrupr_pkg::upd_t      upd_i,
  input  lrupr_pkg::idx_t      last_idx_i,
  input  logic                 clear_i
);

  lrupr_pkg::page_t page_q  [lrupr_pkg::NumFrames];
  logic             valid_q [lrupr_pkg::NumFrames];
  logic             valid_d [lrupr_pkg::NumFrames];
  lrupr_pkg::rank_t rank_q  [lrupr_pkg::NumFrames];
  lrupr_pkg::rank_t rank_d  [lrupr_pkg::NumFrames];

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];
  assign rd_page_o  = page_q[rd_idx_i];

  always_comb begin
    for (int i = 0; i < lrupr_pkg::NumFrames; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
      if (upd_i.en) begin
        if (lrupr_pkg::idx_t'(i) == upd_i.slot) begin
          rank_d[i] = '0;
          if (upd_i.set_valid) begin
            valid_d[i] = 1'b1;
          end
        end else if (lrupr_pkg::idx_t'(i) <= last_idx_i && valid_q[i] &&
                     {1'b0, rank_q[i]} < upd_i.old_rank &&
                     rank_q[i] != lrupr_pkg::RankMax) begin
          rank_d[i] = rank_q[i] + lrupr_pkg::rank_t'(1);
        end
      end
      if (clear_i) begin
        valid_d[i] = 1'b0;
        rank_d[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lrupr_pkg::NumFrames; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < lrupr_pkg::NumFrames; i++) begin
        valid_q[i] <= valid_d[i];
        rank_q[i]  <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.write_page) begin
      page_q[upd_i.slot] <= upd_i.page;
    end
  end

endmodule

// File: rtl/core/lrupr_scan.sv
// ----------------------------------------------------------------------------
// lrupr_scan
// Compare unit stepped once per frame: finds the hit, the first empty frame
// and the least recently used frame in a single pass.
// ----------------------------------------------------------------------------
module lrupr_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 step_i,
  input  lrupr_pkg::idx_t      idx_i,
  input  logic                 ent_valid_i,
  input  lrupr_pkg::rank_t     ent_rank_i,
  input  lrupr_pkg::page_t     ent_page_i,
  input  lrupr_pkg::page_t     req_page_i,
  output lrupr_pkg::scan_t     res_o
);

  lrupr_pkg::scan_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (start_i) begin
      res_d.hit   = 1'b0;
      res_d.empty = 1'b0;
    end else if (step_i) begin
      if (!res_q.hit && ent_valid_i && ent_page_i == req_page_i) begin
        res_d.hit      = 1'b1;
        res_d.hit_idx  = idx_i;
        res_d.hit_rank = ent_rank_i;
      end
      if (!res_q.empty && !ent_valid_i) begin
        res_d.empty     = 1'b1;
        res_d.empty_idx = idx_i;
      end
      // strictly greater keeps the lowest index on a tie
      if (idx_i == '0 || ent_rank_i > res_q.vic_rank) begin
        res_d.vic_idx  = idx_i;
        res_d.vic_rank = ent_rank_i;
        res_d.vic_page = ent_page_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over up to sixteen fully associative page frames.
// ----------------------------------------------------------------------------
// Each reference passes an accept step, a scan of the frames in use and an
// update step; the scan uses the single compare unit, which visits one frame
// per cycle. The result is held in an output register, and the next
// reference is accepted while it waits. frames_in_use is to be written
// through the cfg channel only while the block is idle; the block itself
// does not enforce this. 0 acts as 1 and values above 16 act as 16.
// A reference with tlast set clears frames, ranks and the fault total after its result.
module lru_page_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,      // frames_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // page
  input  logic        s_axis_tlast,    // last_reference
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // frame, evicted_page, fault_total, zero pad
  output logic [1:0]  m_axis_tuser,    // hit, evicted_valid
  output logic        m_axis_tlast     // done_res
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDecide
  } state_e;

  state_e                     state_q;
  logic [lrupr_pkg::CfgW-1:0] cfg_q;
  lrupr_pkg::idx_t            idx_q;
  lrupr_pkg::idx_t            last_idx_q;
  lrupr_pkg::idx_t            last_idx;
  lrupr_pkg::page_t           req_page_q;
  logic                       req_last_q;
  logic [lrupr_pkg::CntW-1:0] fault_q;
  logic [lrupr_pkg::CntW-1:0] fault_d;

  logic                       out_valid_q;
  logic                       out_hit_q;
  logic                       out_ev_valid_q;
  lrupr_pkg::idx_t            out_frame_q;
  lrupr_pkg::page_t           out_ev_page_q;
  logic [lrupr_pkg::CntW-1:0] out_fault_q;
  logic                       out_last_q;

  logic                       in_fire;
  logic                       out_free;
  logic                       load;
  logic                       ent_valid;
  lrupr_pkg::rank_t           ent_rank;
  lrupr_pkg::page_t           ent_page;
  lrupr_pkg::scan_t           scan;
  lrupr_pkg::upd_t            upd;
  logic                       ev_valid;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load          = (state_q == StDecide) && out_free;

  always_comb begin
    if (cfg_q == '0) begin
      last_idx = '0;
    end else if (cfg_q > lrupr_pkg::CfgW'(lrupr_pkg::NumFrames)) begin
      last_idx = lrupr_pkg::idx_t'(lrupr_pkg::NumFrames - 1);
    end else begin
      last_idx = lrupr_pkg::idx_t'(cfg_q - lrupr_pkg::CfgW'(1));
    end
  end

  // pick the frame to use from the pass result
  always_comb begin
    upd      = '0;
    ev_valid = 1'b0;
    upd.en   = load;
    upd.page = req_page_q;
    if (scan.hit) begin
      upd.slot     = scan.hit_idx;
      upd.old_rank = {1'b0, scan.hit_rank};
    end else if (scan.empty) begin
      upd.slot       = scan.empty_idx;
      upd.old_rank   = lrupr_pkg::EmptyRank;
      upd.write_page = 1'b1;
      upd.set_valid  = 1'b1;
    end else begin
      upd.slot       = scan.vic_idx;
      upd.old_rank   = {1'b0, scan.vic_rank};
      upd.write_page = 1'b1;
      ev_valid       = 1'b1;
    end
    fault_d = fault_q;
    if (!scan.hit && fault_q != '1) begin
      fault_d = fault_q + lrupr_pkg::CntW'(1);
    end
  end

  lrupr_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_valid_o (ent_valid),
    .rd_rank_o  (ent_rank),
    .rd_page_o  (ent_page),
    .upd_i      (upd),
    .last_idx_i (last_idx_q),
    .clear_i    (load && req_last_q)
  );

  lrupr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .step_i      (state_q == StScan),
    .idx_i       (idx_q),
    .ent_valid_i (ent_valid),
    .ent_rank_i  (ent_rank),
    .ent_page_i  (ent_page),
    .req_page_i  (req_page_q),
    .res_o       (scan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_q       <= lrupr_pkg::CfgW'(4);
      idx_q       <= '0;
      last_idx_q  <= '0;
      req_last_q  <= 1'b0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            idx_q      <= '0;
            last_idx_q <= last_idx;
            req_last_q <= s_axis_tlast;
            state_q    <= StScan;
          end
        end
        StScan: begin
          if (idx_q == last_idx_q) begin
            state_q <= StDecide;
          end else begin
            idx_q <= idx_q + lrupr_pkg::idx_t'(1);
          end
        end
        StDecide: begin
          if (out_free) begin
            fault_q <= req_last_q ? '0 : fault_d;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_page_q <= s_axis_tdata;
    end
    if (load) begin
      out_hit_q      <= scan.hit;
      out_frame_q    <= upd.slot;
      out_ev_valid_q <= ev_valid;
      out_ev_page_q  <= ev_valid ? scan.vic_page : '0;
      out_fault_q    <= fault_d;
      out_last_q     <= req_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_fault_q, out_ev_page_q, out_frame_q};
  assign m_axis_tuser  = {out_ev_valid_q, out_hit_q};
  assign m_axis_tlast  = out_last_q;

  a_last_clears_faults : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && req_last_q) |=> (fault_q == '0))
    else $error("fault total not cleared after last reference");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (idx_q <= last_idx_q))
    else $error("scan index beyond frames in use");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (m_axis_tvalid && !(out_hit_q && out_ev_valid_q)))
    else $error("result lost or hit reported with eviction");

endmodule
